### hw/rtl/jfps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jfps_pkg;

    // Grid geometry. A cell address is the row and column bits side by side,
    // so the stores are sized to the next power of two of each dimension.
    localparam int unsigned ROWS      = 64;
    localparam int unsigned COLS      = 64;
    localparam int unsigned ROW_W     = $clog2(ROWS);
    localparam int unsigned COL_W     = $clog2(COLS);
    localparam int unsigned ADDR_W    = ROW_W + COL_W;
    localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

    // Signed Q4.12 cell values; the four-neighbor sum needs two more bits.
    localparam int unsigned VAL_W = 16;
    localparam int unsigned SUM_W = VAL_W + 2;
    localparam int unsigned CNT_W = 16;

    typedef logic signed [VAL_W-1:0] cell_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE_DONE = 2'd0,
        KIND_RUN_DONE   = 2'd1,
        KIND_READ_DATA  = 2'd2
    } kind_t;

    typedef struct packed {
        op_t         operation;
        logic [5:0]  row;
        logic [5:0]  col;
        cell_t       value;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        cell_t cell_value;
    } res_t;

    // Store accesses requested by the sweep sequencer.
    typedef struct packed {
        addr_t rd_addr_a;
        addr_t rd_addr_b;
        logic  wr_en;
        addr_t wr_addr;
        cell_t wr_data;
    } seq_mem_t;

    typedef struct packed {
        logic sweep_done;
        logic run_done;
    } seq_status_t;

endpackage

`default_nettype wire

### hw/rtl/jfps_grid_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module jfps_grid_ram
    import jfps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  wr_en,
    input  wire addr_t wr_addr,
    input  wire cell_t wr_data,
    input  wire addr_t rd_addr_a,
    input  wire addr_t rd_addr_b,
    output cell_t      rd_data_a,
    output cell_t      rd_data_b
);

    cell_t store_reg [MEM_DEPTH];
    cell_t rd_a_reg;
    cell_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= store_reg[rd_addr_a];
        rd_b_reg <= store_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

### hw/rtl/jfps_sweep_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module jfps_sweep_seq
    import jfps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire count_t sweep_count,
    input  wire cell_t  src_data_a,
    input  wire cell_t  src_data_b,
    output seq_mem_t    mem,
    output seq_status_t stat
);

    typedef enum logic [3:0] {
        Q_IDLE    = 4'b0001,
        Q_READ_NS = 4'b0010,
        Q_READ_WE = 4'b0100,
        Q_DRAIN   = 4'b1000
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    count_t left_reg, left_next;
    logic done_reg, done_next;

    // Read data tags: which pair of neighbors arrives, and whether each is in the grid.
    logic a_vld_reg, a_vld_next;
    logic b_vld_reg, b_vld_next;
    logic oka_reg, oka_next;
    logic okb_reg, okb_next;
    addr_t b_addr_reg, b_addr_next;
    sum_t sum_ab_reg;

    logic n_ok, s_ok, w_ok, e_ok, last_cell;
    sum_t base, op_a, op_b, sum;

    assign n_ok = (row_reg != '0);
    assign s_ok = (row_reg != ROW_W'(ROWS - 1));
    assign w_ok = (col_reg != '0);
    assign e_ok = (col_reg != COL_W'(COLS - 1));
    assign last_cell = !s_ok && !e_ok;

    // The one shared adder: north plus south first, then that plus west and east.
    assign base = b_vld_reg ? sum_ab_reg : '0;
    assign op_a = oka_reg ? SUM_W'(src_data_a) : '0;
    assign op_b = okb_reg ? SUM_W'(src_data_b) : '0;
    assign sum  = base + op_a + op_b;

    always_comb
    begin
        if (state_reg == Q_READ_NS)
        begin
            mem.rd_addr_a = {row_reg - ROW_W'(1), col_reg};
            mem.rd_addr_b = {row_reg + ROW_W'(1), col_reg};
        end
        else
        begin
            mem.rd_addr_a = {row_reg, col_reg - COL_W'(1)};
            mem.rd_addr_b = {row_reg, col_reg + COL_W'(1)};
        end
        mem.wr_en   = b_vld_reg;
        mem.wr_addr = b_addr_reg;
        mem.wr_data = sum[SUM_W-1:2];
    end

    assign stat.sweep_done = (state_reg == Q_DRAIN);
    assign stat.run_done   = done_reg;

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        left_next   = left_reg;
        done_next   = 1'b0;
        a_vld_next  = 1'b0;
        b_vld_next  = 1'b0;
        oka_next    = 1'b0;
        okb_next    = 1'b0;
        b_addr_next = b_addr_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    if (sweep_count == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        left_next  = sweep_count;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = Q_READ_NS;
                    end
                end
            end
            Q_READ_NS:
            begin
                a_vld_next = 1'b1;
                oka_next   = n_ok;
                okb_next   = s_ok;
                state_next = Q_READ_WE;
            end
            Q_READ_WE:
            begin
                b_vld_next  = 1'b1;
                oka_next    = w_ok;
                okb_next    = e_ok;
                b_addr_next = {row_reg, col_reg};
                if (last_cell)
                begin
                    state_next = Q_DRAIN;
                end
                else
                begin
                    if (!e_ok)
                    begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                    state_next = Q_READ_NS;
                end
            end
            Q_DRAIN:
            begin
                // The last cell is written at the end of this cycle.
                row_next = '0;
                col_next = '0;
                if (left_reg == count_t'(1))
                begin
                    done_next  = 1'b1;
                    state_next = Q_IDLE;
                end
                else
                begin
                    left_next  = left_reg - count_t'(1);
                    state_next = Q_READ_NS;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            oka_reg   <= 1'b0;
            okb_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
            oka_reg   <= oka_next;
            okb_reg   <= okb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        left_reg   <= left_next;
        b_addr_reg <= b_addr_next;
        if (a_vld_reg)
        begin
            sum_ab_reg <= sum;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/jacobi_four_point_stencil_sweeps_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                          | Direction | Carries
// ---------+----------------------------------+-----------+------------------------------
// cmd      | cmd_valid, cmd_ready, cmd        | in        | write, run or read request
// res      | res_valid, res_ready, res        | out       | one result per write, run or read
// cfg      | cfg_valid, cfg_ready, cfg_data   | in        | sweep count register
//
// Writes stream one per cycle while results are taken.
// A read request passes through S_READ, which waits on the registered read of the grid store.
// In a run request each cell is visited in Q_READ_NS and then in Q_READ_WE, because the shared
// adder gets two neighbors per cycle from the two store read ports.
// Reset clears the control state and makes store A current; the stores themselves hold
// nothing defined until written. A stalled result blocks new requests but no ongoing sweep.

module jacobi_four_point_stencil_sweeps_core
    import jfps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cmd_valid,
    output logic        cmd_ready,
    input  wire cmd_t   cmd,
    output logic        res_valid,
    input  wire logic   res_ready,
    output res_t        res,
    input  wire logic   cfg_valid,
    output logic        cfg_ready,
    input  wire count_t cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RUN  = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;
    logic sel_reg;
    count_t sweep_count_reg;
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;
    logic res_load;
    logic rd_inside_reg, rd_inside_next;

    logic cmd_fire, on_grid, item_we, seq_start;
    addr_t item_addr;
    seq_mem_t seq_mem;
    seq_status_t seq_stat;

    addr_t ram_rd_addr_a, ram_rd_addr_b, ram_wr_addr;
    cell_t ram_wr_data;
    logic we_a, we_b;
    cell_t a_rd_a, a_rd_b, b_rd_a, b_rd_b;
    cell_t src_a, src_b;

    // The configuration register can always be written; the block is idle by contract.
    assign cfg_ready = 1'b1;

    // A new request needs the result register free by the next edge.
    assign cmd_ready = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign on_grid   = (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLS);
    assign item_addr = {cmd.row[ROW_W-1:0], cmd.col[COL_W-1:0]};
    assign item_we   = cmd_fire && (cmd.operation == OP_WRITE) && on_grid;
    assign seq_start = cmd_fire && (cmd.operation == OP_RUN);

    // Requests touch the current store; a sweep reads the current store and writes
    // the other one. Request and sweep accesses never overlap in time.
    assign ram_rd_addr_a = (state_reg == S_RUN) ? seq_mem.rd_addr_a : item_addr;
    assign ram_rd_addr_b = seq_mem.rd_addr_b;
    assign ram_wr_addr   = seq_mem.wr_en ? seq_mem.wr_addr : item_addr;
    assign ram_wr_data   = seq_mem.wr_en ? seq_mem.wr_data : cmd.value;
    assign we_a = (item_we && !sel_reg) || (seq_mem.wr_en && sel_reg);
    assign we_b = (item_we && sel_reg) || (seq_mem.wr_en && !sel_reg);

    assign src_a = sel_reg ? b_rd_a : a_rd_a;
    assign src_b = sel_reg ? b_rd_b : a_rd_b;

    jfps_grid_ram u_store_a (
        .clk       (clk),
        .wr_en     (we_a),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_a (a_rd_a),
        .rd_data_b (a_rd_b)
    );

    jfps_grid_ram u_store_b (
        .clk       (clk),
        .wr_en     (we_b),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_a (b_rd_a),
        .rd_data_b (b_rd_b)
    );

    jfps_sweep_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (seq_start),
        .sweep_count (sweep_count_reg),
        .src_data_a  (src_a),
        .src_data_b  (src_b),
        .mem         (seq_mem),
        .stat        (seq_stat)
    );

    // Request sequencing and loading of the result register.
    always_comb
    begin
        state_next     = state_reg;
        res_load       = 1'b0;
        res_next       = res_reg;
        rd_inside_next = rd_inside_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.operation)
                        OP_WRITE:
                        begin
                            res_load = 1'b1;
                            res_next = '{kind: KIND_WRITE_DONE, cell_value: '0};
                        end
                        OP_RUN:
                        begin
                            state_next = S_RUN;
                        end
                        OP_READ:
                        begin
                            rd_inside_next = on_grid;
                            state_next     = S_READ;
                        end
                        default:
                        begin
                            // The unused code is taken and answered with nothing.
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load   = 1'b1;
                res_next   = '{kind: KIND_READ_DATA, cell_value: rd_inside_reg ? src_a : '0};
                state_next = S_IDLE;
            end
            S_RUN:
            begin
                if (seq_stat.run_done)
                begin
                    res_load   = 1'b1;
                    res_next   = '{kind: KIND_RUN_DONE, cell_value: '0};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sel_reg         <= 1'b0;
            sweep_count_reg <= count_t'(1);
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_reg ^ seq_stat.sweep_done;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                sweep_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        rd_inside_reg <= rd_inside_next;
    end

    // Sweep writes to the stores happen only while a run request is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_mem.wr_en |-> (state_reg == S_RUN))
        else $error("sweep write outside a run");

    // The sequencer reports completion only to a waiting run request.
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.run_done |-> (state_reg == S_RUN))
        else $error("run completion without a run request");

    // The current store changes only at the end of a sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != $past(sel_reg)) |-> $past(seq_stat.sweep_done))
        else $error("store select changed outside a sweep end");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || res_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import jfps_pkg::*;

    // Timing of the run. A run request with the largest sweep count that is run here
    // (four) keeps every channel quiet through four sweeps over every cell, so
    // the watchdog allows several times that long before it declares the block stuck.
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int GRID_ROWS      = ROWS;
    localparam int GRID_COLS      = COLS;
    localparam int GRID_CELLS     = GRID_ROWS * GRID_COLS;

    // The operation code that the block ignores: it gives no result.
    localparam op_t OP_UNUSED = op_t'(2'd3);

    localparam cell_t CELL_MAX = 16'sh7FFF;
    localparam cell_t CELL_MIN = 16'sh8000;

    // One entry of the stimulus plan. Besides requests, the plan holds register writes
    // and drain points; both hold the sender until the block has answered everything.
    typedef enum int {
        STEP_REQUEST,
        STEP_SWEEP_COUNT,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t what;
        cmd_t       request;
        count_t     sweeps;
    } step_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   cmd_valid = 1'b0;
    logic   cmd_ready;
    cmd_t   cmd       = '0;
    logic   res_valid;
    logic   res_ready = 1'b0;
    res_t   res;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    count_t cfg_data  = '0;

    step_t  pending_steps[$];
    res_t   awaited_results[$];

    // Predicted state of the block: both ping-pong planes, which one is live,
    // and the sweep count register.
    cell_t  cell_plane[2][GRID_CELLS];
    bit     live_plane     = 1'b0;
    count_t sweeps_per_run = count_t'(1);

    int     error_count  = 0;
    int     idle_cycles  = 0;
    int     gap_left     = 0;
    int     quiet_cycles = 0;
    int     send_calm    = 0;
    int     stall_left   = 0;
    int     recv_calm    = 0;

    jacobi_four_point_stencil_sweeps_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(string what);
        $display("tb: mismatch: %s", what);
        error_count++;
    endtask

    // Cells beyond the edge of the grid are the fixed zero border.
    function automatic int neighbor_value(bit plane, int r, int c);
        if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
            return 0;
        return int'(cell_plane[plane][r * GRID_COLS + c]);
    endfunction

    // One Jacobi sweep from the live plane into the other one. The arithmetic
    // shift of the four-term sum floors, and the quotient always fits in Q4.12.
    function automatic void relax_once();
        int total;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                total = neighbor_value(live_plane, r - 1, c)
                      + neighbor_value(live_plane, r + 1, c)
                      + neighbor_value(live_plane, r, c - 1)
                      + neighbor_value(live_plane, r, c + 1);
                cell_plane[!live_plane][r * GRID_COLS + c] = cell_t'(total >>> 2);
            end
        end
        live_plane = !live_plane;
    endfunction

    // Updates the predicted grid for an accepted request and queues the result it owes.
    function automatic void apply_request(cmd_t c);
        res_t  want;
        bit    on_grid;
        int    cell_idx;
        on_grid  = (int'(c.row) < GRID_ROWS) && (int'(c.col) < GRID_COLS);
        cell_idx = int'(c.row) * GRID_COLS + int'(c.col);
        want     = '{kind: KIND_WRITE_DONE, cell_value: '0};
        case (c.operation)
            OP_WRITE:
            begin
                if (on_grid)
                    cell_plane[live_plane][cell_idx] = c.value;
                awaited_results.push_back(want);
            end
            OP_RUN:
            begin
                for (int k = 0; k < int'(sweeps_per_run); k++)
                    relax_once();
                want.kind = KIND_RUN_DONE;
                awaited_results.push_back(want);
            end
            OP_READ:
            begin
                want.kind = KIND_READ_DATA;
                if (on_grid)
                    want.cell_value = cell_plane[live_plane][cell_idx];
                awaited_results.push_back(want);
            end
            default:
            begin
                // The unused code is dropped by the block without a result.
            end
        endcase
    endfunction

    task automatic check_result(res_t got);
        res_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing outstanding: kind %0d value %0d",
                                      got.kind, got.cell_value));
            return;
        end
        want = awaited_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.cell_value !== want.cell_value)
            report_mismatch($sformatf("cell_value %0d, expected %0d (kind %0d)",
                                      got.cell_value, want.cell_value, want.kind));
    endtask

    // Wait drawn before each request or each result. Now and then a calm stretch
    // of back-to-back transfers is mixed in.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(15, 60);
        return $urandom_range(0, 12);
    endfunction

    function automatic void add_request(op_t op, int r, int c, cell_t v);
        step_t s;
        s.what    = STEP_REQUEST;
        s.request = '{operation: op, row: 6'(r), col: 6'(c), value: v};
        s.sweeps  = '0;
        pending_steps.push_back(s);
    endfunction

    function automatic void add_sweep_count(count_t n);
        step_t s;
        s.what    = STEP_SWEEP_COUNT;
        s.request = '0;
        s.sweeps  = n;
        pending_steps.push_back(s);
    endfunction

    function automatic void add_drain();
        step_t s;
        s.what    = STEP_DRAIN;
        s.request = '0;
        s.sweeps  = '0;
        pending_steps.push_back(s);
    endfunction

    // Written values lean toward the two extremes so that the floor of the
    // four-term sum is exercised at both ends of the range.
    function automatic cell_t random_cell();
        case ($urandom_range(0, 7))
            0: return CELL_MAX;
            1: return CELL_MIN;
            default: return cell_t'($urandom);
        endcase
    endfunction

    // Request driver. The next request is presented at the very edge that takes the previous
    // one when its drawn wait is zero, so valid never drops in between.
    // Register writes and drain points wait until no result is owed and the block
    // has stayed quiet for the settle period, which also covers an ignored request
    // that may still be in flight.
    always @(posedge clk)
    begin : drive_requests
        logic  next_cmd_valid;
        logic  next_cfg_valid;
        step_t head;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            next_cmd_valid = cmd_valid;
            next_cfg_valid = cfg_valid;
            if (cmd_valid && cmd_ready)
            begin
                apply_request(cmd);
                next_cmd_valid = 1'b0;
                gap_left = draw_wait(send_calm);
            end
            if (cfg_valid && cfg_ready)
            begin
                sweeps_per_run = cfg_data;
                next_cfg_valid = 1'b0;
            end
            if (awaited_results.size() != 0 || next_cmd_valid || next_cfg_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (!next_cmd_valid && !next_cfg_valid && pending_steps.size() != 0)
            begin
                head = pending_steps[0];
                if (head.what == STEP_REQUEST)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        void'(pending_steps.pop_front());
                        cmd <= head.request;
                        next_cmd_valid = 1'b1;
                    end
                end
                else if (quiet_cycles >= SETTLE_CYCLES)
                begin
                    void'(pending_steps.pop_front());
                    if (head.what == STEP_SWEEP_COUNT)
                    begin
                        cfg_data <= head.sweeps;
                        next_cfg_valid = 1'b1;
                    end
                end
            end
            cmd_valid <= next_cmd_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // Result monitor. After each result it draws a stall and holds ready low while
    // the stall counts down, so stalls land on every phase of the block's work.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                check_result(res);
                stall_left = draw_wait(recv_calm);
            end
            else if (stall_left > 0)
                stall_left--;
            res_ready <= (stall_left == 0);
        end
    end

    // Cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        count_t phase_sweeps;
        int     roll;

        // Directed part. A read only ever touches a cell that has been written, so
        // the early reads use cells loaded just before. The ignored code goes to a
        // cell that is then read back, which shows that it changed nothing.
        add_request(OP_WRITE, 0, 0, CELL_MAX);
        add_request(OP_WRITE, 63, 63, CELL_MIN);
        add_request(OP_WRITE, 21, 42, 16'sh5555);
        add_request(OP_READ, 0, 0, '0);
        add_request(OP_READ, 63, 63, 16'sh7FFF);
        add_request(OP_UNUSED, 63, 63, 16'shFFFF);
        add_request(OP_READ, 63, 63, '0);
        add_request(OP_READ, 21, 42, '0);

        // Every cell must hold data before the first sweep. The top band is all
        // maximum and the next band all minimum, so the stencil sees both extreme
        // sums; the rest is random.
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                if (r < 8)
                    add_request(OP_WRITE, r, c, CELL_MAX);
                else if (r < 16)
                    add_request(OP_WRITE, r, c, CELL_MIN);
                else
                    add_request(OP_WRITE, r, c, cell_t'($urandom));
            end
        end

        // First run uses the sweep count left by reset.
        add_request(OP_RUN, 0, 0, '0);
        add_request(OP_READ, 0, 0, '0);
        add_request(OP_READ, 63, 63, '0);
        add_request(OP_READ, 8, 30, '0);
        add_request(OP_READ, 40, 40, '0);
        // A zero sweep count still completes the run but leaves the grid alone.
        add_sweep_count(count_t'(0));
        add_request(OP_RUN, 0, 0, '0);
        add_request(OP_READ, 7, 7, '0);
        // The largest count is only ever loaded, never run: it would take hours.
        add_sweep_count(count_t'(16'hFFFF));
        add_request(OP_WRITE, 1, 1, CELL_MIN);
        add_request(OP_READ, 1, 1, '0);
        add_sweep_count(count_t'(2));
        add_request(OP_RUN, 0, 0, '0);
        add_request(OP_READ, 1, 1, '0);

        // Random part, in phases that each start with a new sweep count. Runs are
        // rare because each sweep visits every cell of the grid.
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 3)
                phase_sweeps = count_t'(16'hFFFF);
            else if (phase == 7)
                phase_sweeps = count_t'(4);
            else
                phase_sweeps = count_t'($urandom_range(0, 3));
            add_sweep_count(phase_sweeps);
            for (int i = 0; i < 120; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2 && phase_sweeps <= count_t'(4))
                    add_request(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                                cell_t'($urandom));
                else if (roll < 6)
                    add_request(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                cell_t'($urandom));
                else if (roll < 8)
                    add_drain();
                else if (roll < 52)
                    add_request(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                                random_cell());
                else
                    add_request(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                                cell_t'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until the plan is used up and every owed result has come back.
        while (!(pending_steps.size() == 0 && !cmd_valid && !cfg_valid
                 && awaited_results.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);

        if (idle_cycles >= WATCHDOG_LIMIT)
            $display("tb: done, errors");
        else
        begin
            // Wait out a tail so that a stray result would still be caught.
            repeat (TAIL_CYCLES) @(posedge clk);
            if (error_count == 0)
                $display("tb: done, clean");
            else
                $display("tb: done, errors");
        end
        $finish;
    end

endmodule
